// ===== design/md5_message_digest_core_defines.svh =====
// Assertion macros shared by the MD5 core modules.
`ifndef MD5_MESSAGE_DIGEST_CORE_DEFINES_SVH
`define MD5_MESSAGE_DIGEST_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define MD5_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define MD5_ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define MD5_ASSERT(label, clk, rst_n, prop)
`define MD5_ASSERT_NORST(label, clk, prop)
`endif
`endif

// ===== design/md5_pkg.sv =====
// Package with MD5 constants, tables, and controller/datapath types.
package md5_pkg;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;
  localparam logic [7:0]  PadByte = 8'h80;
  localparam logic [5:0]  PosMask = 6'h3F;
  localparam logic [5:0]  LenPos  = 6'd56;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMP,
    ST_PAD,
    ST_LEN,
    ST_FINAL,
    ST_OUT
  } md5_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       put_byte;   // write put_val at the current block position
    logic [7:0] put_val;
    logic       count_inc;  // advance the byte count
    logic       pad_inc;    // advance the padding position
    logic       pad_start;  // load the padding position from the byte count plus one
    logic       put_len;    // write the bit length into words 14 and 15
    logic       comp_start;
    logic       round_en;
    logic       comp_done;  // add working words into chaining words
    logic       reload;     // initial chaining words and zero count
  } md5_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       count_full; // byte count position is 63
    logic       pad_full;   // padding position is 63
    logic       last_round;
    logic       pad_at_len; // padding position is 56
  } md5_stat_t;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] round_shift(input logic [3:0] idx);
    logic [4:0] s;
    case (idx)
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

endpackage

// ===== design/md5_datapath.sv =====
// MD5 datapath: block buffer, byte count, chaining words and the round unit.
`include "md5_message_digest_core_defines.svh"
module md5_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  md5_pkg::md5_cmd_t  cmd_i,
  output md5_pkg::md5_stat_t stat_o,
  output logic [127:0]       chain_o
);

  logic [31:0] blk_q [16];
  logic [60:0] total_q, total_d;
  logic [5:0]  pad_q, pad_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [31:0] h_q [4];
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [5:0]  wpos;
  logic [3:0]  widx;
  logic [1:0]  lane;
  logic [63:0] bits;
  logic [31:0] f, sum, rot;
  logic [3:0]  g;
  logic [4:0]  sh;
  logic [1:0]  grp;

  // Write position: the pad pointer while zero-filling, else the byte count.
  assign wpos  = cmd_i.pad_inc ? pad_q : total_q[5:0];
  assign widx  = wpos[5:2];
  assign lane  = wpos[1:0];
  assign bits  = {total_q, 3'b000};

  assign stat_o.count_full = ((total_q[5:0] & md5_pkg::PosMask) == md5_pkg::PosMask);
  assign stat_o.pad_full   = ((pad_q & md5_pkg::PosMask) == md5_pkg::PosMask);
  assign stat_o.last_round = (rnd_q == 6'd63);
  assign stat_o.pad_at_len = (pad_q == md5_pkg::LenPos);

  // Block buffer byte lanes and length words.
  always_ff @(posedge clk_i) begin
    if (cmd_i.put_byte) begin
      if (lane == 2'd0) begin
        blk_q[widx] <= {24'd0, cmd_i.put_val};
      end else begin
        blk_q[widx][lane*8 +: 8] <= cmd_i.put_val;
      end
    end
    if (cmd_i.put_len) begin
      blk_q[14] <= bits[31:0];
      blk_q[15] <= bits[63:32];
    end
  end

  // Byte count and padding pointer.
  always_comb begin
    total_d = total_q;
    pad_d   = pad_q;
    if (cmd_i.count_inc) total_d = total_q + 61'd1;
    if (cmd_i.pad_start) pad_d = total_q[5:0] + 6'd1;
    if (cmd_i.pad_inc)   pad_d = pad_q + 6'd1;
    if (cmd_i.reload)    total_d = '0;
  end

  // Round function selection.
  assign grp = rnd_q[5:4];
  always_comb begin
    case (grp)
      2'd0: begin
        f = (b_q & c_q) | (~b_q & d_q);
        g = rnd_q[3:0];
      end
      2'd1: begin
        f = (b_q & d_q) | (c_q & ~d_q);
        g = 4'(5 * rnd_q + 1);
      end
      2'd2: begin
        f = b_q ^ c_q ^ d_q;
        g = 4'(3 * rnd_q + 5);
      end
      default: begin
        f = c_q ^ (b_q | ~d_q);
        g = 4'(7 * rnd_q);
      end
    endcase
    sh  = md5_pkg::round_shift({grp, rnd_q[1:0]});
    sum = a_q + f + md5_pkg::round_k(rnd_q) + blk_q[g];
    rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
  end

  assign rnd_d = cmd_i.comp_start ? 6'd0 : (cmd_i.round_en ? rnd_q + 6'd1 : rnd_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      pad_q   <= '0;
      rnd_q   <= '0;
      h_q[0]  <= md5_pkg::InitA;
      h_q[1]  <= md5_pkg::InitB;
      h_q[2]  <= md5_pkg::InitC;
      h_q[3]  <= md5_pkg::InitD;
    end else begin
      total_q <= total_d;
      pad_q   <= pad_d;
      rnd_q   <= rnd_d;
      if (cmd_i.reload) begin
        h_q[0] <= md5_pkg::InitA;
        h_q[1] <= md5_pkg::InitB;
        h_q[2] <= md5_pkg::InitC;
        h_q[3] <= md5_pkg::InitD;
      end else if (cmd_i.comp_done) begin
        h_q[0] <= h_q[0] + a_q;
        h_q[1] <= h_q[1] + b_q;
        h_q[2] <= h_q[2] + c_q;
        h_q[3] <= h_q[3] + d_q;
      end
    end
  end

  // Working words.
  always_ff @(posedge clk_i) begin
    if (cmd_i.comp_start) begin
      a_q <= h_q[0];
      b_q <= h_q[1];
      c_q <= h_q[2];
      d_q <= h_q[3];
    end else if (cmd_i.round_en) begin
      a_q <= d_q;
      d_q <= c_q;
      c_q <= b_q;
      b_q <= b_q + rot;
    end
  end

  assign chain_o = {h_q[3], h_q[2], h_q[1], h_q[0]};

  `MD5_ASSERT(a_round_no_write, clk_i, rst_ni, cmd_i.round_en |-> !cmd_i.put_byte)
  `MD5_ASSERT(a_reload_zero, clk_i, rst_ni, cmd_i.reload |=> total_q == '0)
  `MD5_ASSERT(a_start_round0, clk_i, rst_ni, cmd_i.comp_start |=> rnd_q == 6'd0)

endmodule

// ===== design/md5_ctrl.sv =====
// MD5 controller: sequences byte writes, compressions, padding and digest output.
`include "md5_message_digest_core_defines.svh"
module md5_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         in_byte_i,
  input  logic               in_bvalid_i,
  input  logic               in_end_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [1:0]         out_num_o,
  input  md5_pkg::md5_stat_t stat_i,
  output md5_pkg::md5_cmd_t  cmd_o
);

  md5_pkg::md5_state_e state_q, state_d;
  md5_pkg::md5_state_e ret_q, ret_d;
  logic [1:0] num_q, num_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= md5_pkg::ST_IDLE;
      ret_q   <= md5_pkg::ST_IDLE;
      num_q   <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      num_q   <= num_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    num_d       = num_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      md5_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_bvalid_i) begin
            cmd_o.put_byte  = 1'b1;
            cmd_o.put_val   = in_byte_i;
            cmd_o.count_inc = 1'b1;
            if (stat_i.count_full) begin
              cmd_o.comp_start = 1'b1;
              state_d = md5_pkg::ST_COMP;
              ret_d   = in_end_i ? md5_pkg::ST_PAD : md5_pkg::ST_IDLE;
            end else if (in_end_i) begin
              state_d = md5_pkg::ST_PAD;
            end
          end else if (in_end_i) begin
            state_d = md5_pkg::ST_PAD;
          end
          if (in_end_i) cmd_o.pad_start = 1'b0;
        end
      end
      md5_pkg::ST_COMP: begin
        cmd_o.round_en = 1'b1;
        if (stat_i.last_round) begin
          state_d = md5_pkg::ST_FINAL;
        end
      end
      md5_pkg::ST_FINAL: begin
        cmd_o.comp_done = 1'b1;
        state_d = ret_q;
        if (ret_q == md5_pkg::ST_OUT) num_d = '0;
      end
      md5_pkg::ST_PAD: begin
        // 0x80 at the byte count position; pad pointer starts just after it.
        cmd_o.put_byte  = 1'b1;
        cmd_o.put_val   = md5_pkg::PadByte;
        cmd_o.pad_start = 1'b1;
        if (stat_i.count_full) begin
          cmd_o.comp_start = 1'b1;
          state_d = md5_pkg::ST_COMP;
          ret_d   = md5_pkg::ST_LEN;
        end else begin
          state_d = md5_pkg::ST_LEN;
        end
      end
      md5_pkg::ST_LEN: begin
        if (stat_i.pad_at_len) begin
          cmd_o.put_len    = 1'b1;
          cmd_o.comp_start = 1'b1;
          state_d = md5_pkg::ST_COMP;
          ret_d   = md5_pkg::ST_OUT;
        end else begin
          cmd_o.put_byte = 1'b1;
          cmd_o.put_val  = 8'h00;
          cmd_o.pad_inc  = 1'b1;
          if (stat_i.pad_full) begin
            cmd_o.comp_start = 1'b1;
            state_d = md5_pkg::ST_COMP;
            ret_d   = md5_pkg::ST_LEN;
          end
        end
      end
      md5_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          num_d = num_q + 2'd1;
          if (num_q == 2'd3) begin
            cmd_o.reload = 1'b1;
            state_d = md5_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = md5_pkg::ST_IDLE;
    endcase
  end

  assign out_num_o = num_q;

  `MD5_ASSERT(a_out_only_in_out, clk_i, rst_ni,
    out_valid_o |-> state_q == md5_pkg::ST_OUT)
  `MD5_ASSERT(a_ready_idle, clk_i, rst_ni,
    in_ready_o |-> !out_valid_o)
  `MD5_ASSERT(a_last_reload, clk_i, rst_ni,
    (out_valid_o && out_ready_i && num_q == 2'd3) |=> state_q == md5_pkg::ST_IDLE)

endmodule

// ===== design/md5_message_digest_core.sv =====
// Top level of the MD5 core: streaming ports around controller and datapath.
//
//  channel | dir | tdata                     | tuser              | tlast
//  s_axis  | in  | data_byte[7:0]            | byte_valid         | message_end
//  m_axis  | out | digest_word[31:0]         | word_number[1:0]   | last_word
//
// Bytes are taken one per cycle while idle; a byte that fills a block starts
// the 64 rounds of the shared round unit, followed by the chaining update.
// Closing a message pads one byte per cycle to position 56, pausing for each
// of its one or two compressions, then holds the four digest words until each
// is taken. Reset is asynchronous and restores the initial chaining words and
// a zero count; no input is taken while padding, compressing or emitting.
module md5_message_digest_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
  input  logic        s_axis_tuser,   // byte_valid
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // digest_word[31:0]
  output logic [1:0]  m_axis_tuser,   // word_number[1:0]
  output logic        m_axis_tlast
);

  md5_pkg::md5_cmd_t  cmd;
  md5_pkg::md5_stat_t stat;
  logic [127:0]       chain;
  logic [1:0]         num;

  md5_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_bvalid_i (s_axis_tuser),
    .in_end_i    (s_axis_tlast),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_num_o   (num),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  md5_datapath u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .stat_o  (stat),
    .chain_o (chain)
  );

  // Select the digest word being offered.
  assign m_axis_tdata = chain[num*32 +: 32];
  assign m_axis_tuser = num;
  assign m_axis_tlast = (num == 2'd3);

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the MD5 streaming core, with a built-in digest predictor.
`timescale 1ns / 1ps

module tb_top;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  md5_message_digest_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  typedef struct {
    logic [31:0] word;
    logic [1:0]  num;
    logic        last;
  } digest_word_t;

  typedef struct {
    logic [7:0]   data;
    logic         valid;
    logic         close;
    logic         known;      // digest typed in below
    logic [127:0] digest;     // word 3 in the top bits
  } stim_row_t;

  // Round constants and shift amounts of the MD5 transform.
  localparam logic [31:0] RoundK [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
    32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
    32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
    32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
    32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
    32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
  localparam int RotAmt [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  // Digest of the empty message, one word per 32-bit field.
  localparam logic [127:0] EmptyDigest = {32'h7e42f8ec, 32'h980980e9, 32'h04b2008f, 32'hd98c1dd4};

  // Predictor state.
  logic [31:0] chain [4];
  logic [31:0] blk [16];
  logic [60:0] byte_count;

  digest_word_t digest_q [$];
  int           errors;
  int           words_seen;
  int           items_sent;
  bit           calm;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  // One MD5 compression of the gathered block into the chaining words.
  task automatic compress_block();
    logic [31:0] a, b, c, d, f, t;
    int g, r;
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    for (int i = 0; i < 64; i++) begin
      r = i / 16;
      case (r)
        0: begin f = (b & c) | (~b & d); g = i; end
        1: begin f = (b & d) | (c & ~d); g = (5 * i + 1) % 16; end
        2: begin f = b ^ c ^ d;          g = (3 * i + 5) % 16; end
        default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
      endcase
      t = d; d = c; c = b;
      b = b + rotl(a + f + RoundK[i] + blk[g], RotAmt[r * 4 + i % 4]);
      a = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
  endtask

  task automatic store_byte(input int pos, input logic [7:0] v);
    if (pos % 4 == 0) blk[pos / 4] = {24'h0, v};
    else blk[pos / 4][8 * (pos % 4) +: 8] = v;
    if (pos == 63) compress_block();
  endtask

  task automatic reload_chain();
    chain[0] = md5_pkg::InitA; chain[1] = md5_pkg::InitB;
    chain[2] = md5_pkg::InitC; chain[3] = md5_pkg::InitD;
    byte_count = '0;
  endtask

  // Updates the hash state for one accepted request and queues any digest words.
  task automatic predict_digest(input logic [7:0] data, input logic valid, input logic close);
    logic [63:0] bit_len;
    int pos;
    if (valid) begin
      store_byte(int'(byte_count[5:0]), data);
      byte_count = byte_count + 1;
    end
    if (close) begin
      bit_len = {3'b0, byte_count} << 3;
      pos = int'(byte_count[5:0]);
      store_byte(pos, md5_pkg::PadByte);
      pos = (pos + 1) % 64;
      while (pos != 56) begin
        store_byte(pos, 8'h00);
        pos = (pos + 1) % 64;
      end
      blk[14] = bit_len[31:0];
      blk[15] = bit_len[63:32];
      compress_block();
      for (int k = 0; k < 4; k++) digest_q.push_back('{chain[k], 2'(k), k == 3});
      reload_chain();
    end
  endtask

  // Offers one request, waits for acceptance, then updates the predictor.
  task automatic send_request(input logic [7:0] data, input logic valid, input logic close);
    while (!calm && $urandom_range(99) < 12) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= valid;
    s_axis_tlast  <= close;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_digest(data, valid, close);
    items_sent++;
  endtask

  task automatic drain_results();
    while (digest_q.size() != 0) @(posedge clk_i);
  endtask

  // Clock generation.
  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // Result side: compare each accepted word, apply random stalls and one long hold-off.
  initial begin
    int hold;
    digest_word_t exp_w;
    hold = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        words_seen++;
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected word exp none act %h/%0d/%0b", $time,
                   m_axis_tdata, m_axis_tuser, m_axis_tlast);
          errors++;
        end else begin
          exp_w = digest_q.pop_front();
          if (m_axis_tdata !== exp_w.word || m_axis_tuser !== exp_w.num ||
              m_axis_tlast !== exp_w.last) begin
            $display("%0t: digest mismatch exp %h/%0d/%0b act %h/%0d/%0b", $time,
                     exp_w.word, exp_w.num, exp_w.last, m_axis_tdata, m_axis_tuser,
                     m_axis_tlast);
            errors++;
          end
        end
        if (words_seen == 40) hold = 400;
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= 12);
      end
    end
  end

  // Stimulus: directed table, then random messages.
  initial begin
    stim_row_t rows [$];
    int len, n;
    logic close_byte;
    errors = 0; words_seen = 0; items_sent = 0; calm = 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    s_axis_tuser  <= 1'b0;
    s_axis_tlast  <= 1'b0;
    reload_chain();
    foreach (blk[i]) blk[i] = '0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty message right after reset, idle requests, and a few short messages.
    rows.push_back('{8'h00, 1'b0, 1'b1, 1'b1, EmptyDigest});
    rows.push_back('{8'hff, 1'b0, 1'b0, 1'b0, '0});
    rows.push_back('{8'h00, 1'b0, 1'b1, 1'b1, EmptyDigest});
    rows.push_back('{8'hff, 1'b1, 1'b1, 1'b0, '0});
    rows.push_back('{8'h00, 1'b1, 1'b1, 1'b0, '0});
    rows.push_back('{8'h61, 1'b1, 1'b0, 1'b0, '0});
    rows.push_back('{8'h00, 1'b0, 1'b0, 1'b0, '0});
    rows.push_back('{8'h62, 1'b1, 1'b0, 1'b0, '0});
    rows.push_back('{8'h63, 1'b1, 1'b1, 1'b0, '0});
    rows.push_back('{8'h80, 1'b1, 1'b0, 1'b0, '0});
    rows.push_back('{8'h7f, 1'b1, 1'b0, 1'b0, '0});
    rows.push_back('{8'h55, 1'b0, 1'b1, 1'b0, '0});
    foreach (rows[i]) begin
      send_request(rows[i].data, rows[i].valid, rows[i].close);
      if (rows[i].known) begin
        repeat (4) void'(digest_q.pop_back());
        for (int k = 0; k < 4; k++)
          digest_q.push_back('{rows[i].digest[32 * k +: 32], 2'(k), k == 3});
      end
    end

    // Sender pause until every digest has come out.
    s_axis_tvalid <= 1'b0;
    drain_results();
    @(posedge clk_i);

    // Random messages; lengths around the block and padding boundaries now and then.
    n = 0;
    while (items_sent < 250 || n < 8) begin
      calm = (n >= 5 && n < 8);
      case ($urandom_range(9))
        0: len = 55 + $urandom_range(10);
        1: len = 100 + $urandom_range(30);
        default: len = $urandom_range(24);
      endcase
      close_byte = (len > 0) && $urandom_range(1);
      for (int j = 0; j < len; j++) begin
        if ($urandom_range(99) < 8) send_request(8'($urandom), 1'b0, 1'b0);
        send_request(8'($urandom), 1'b1, close_byte && (j == len - 1));
      end
      if (!close_byte) send_request(8'($urandom), 1'b0, 1'b1);
      n++;
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    drain_results();
    repeat (200) @(posedge clk_i);
    if (errors == 0 && digest_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/md5_pkg.sv
design/md5_datapath.sv
design/md5_ctrl.sv
design/md5_message_digest_core.sv
test/tb_top.sv
